// ----- hw/rtl/dcr_pkg.sv -----
// ---------------------------------------------------------------------------
// dcr_pkg
// Types, constants and helpers shared by the dot crawl / rainbow filter.
// ---------------------------------------------------------------------------
package dcr_pkg;

  localparam int PIXEL_BITS = 16;  // active pixel width, 8 to 16
  localparam int PORT_BITS  = 16;  // width of the pixel ports
  localparam int THR_BITS   = 16;  // width of the threshold registers
  localparam int CMP_BITS   = 32;  // common width for threshold compares

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [PIXEL_BITS:0]   sdiff_t;   // magnitude of a second difference
  typedef logic [PORT_BITS-1:0]  port_pix_t;
  typedef logic [THR_BITS-1:0]   thr_t;
  typedef logic [1:0]            cmd_t;
  typedef logic [2:0]            reg_idx_t;

  // plane codes
  localparam cmd_t CMD_LUMA   = 2'd0;
  localparam cmd_t CMD_CHROMA = 2'd1;

  // register indexes
  localparam reg_idx_t REG_MODE            = 3'd0;
  localparam reg_idx_t REG_LUMA_SPATIAL    = 3'd1;
  localparam reg_idx_t REG_LUMA_TEMPORAL   = 3'd2;
  localparam reg_idx_t REG_CHROMA_TEMPORAL = 3'd3;
  localparam reg_idx_t REG_CHROMA_CHANGE   = 3'd4;

  // mode bit positions
  localparam int MODE_LUMA_BIT   = 0;
  localparam int MODE_CHROMA_BIT = 1;

  // reset values
  localparam logic [1:0] MODE_RESET            = 2'd3;
  localparam thr_t       LUMA_SPATIAL_RESET    = 16'd5177;
  localparam thr_t       LUMA_TEMPORAL_RESET   = 16'd5177;
  localparam thr_t       CHROMA_TEMPORAL_RESET = 16'd3801;
  localparam thr_t       CHROMA_CHANGE_RESET   = 16'd1245;

  typedef struct packed {
    logic [1:0] mode;
    thr_t       luma_spatial;
    thr_t       luma_temporal;
    thr_t       chroma_temporal;
    thr_t       chroma_change;
  } cfg_t;

  typedef struct packed {
    cmd_t cmd;
    logic border;
    pix_t cur;
    pix_t up;
    pix_t down;
    pix_t lf;
    pix_t rt;
    pix_t f0;
    pix_t f1;
    pix_t f3;
    pix_t f4;
  } pix_in_t;

  // after the difference stage
  typedef struct packed {
    cmd_t   cmd;
    logic   border;
    pix_t   cur;
    pix_t   f1;
    pix_t   f3;
    sdiff_t sd_v;
    sdiff_t sd_h;
    pix_t   d_f0;
    pix_t   d_f4;
    pix_t   d_13;
    pix_t   d_c1;
    pix_t   d_c3;
  } diff_t;

  // after the decision stage
  typedef struct packed {
    logic fire;
    pix_t cur;
    pix_t other;
  } pick_t;

  function automatic pix_t abs_diff(pix_t a, pix_t b);
    return (a >= b) ? pix_t'(a - b) : pix_t'(b - a);
  endfunction

  function automatic logic le_thr(logic [CMP_BITS-1:0] d, thr_t t);
    return d <= CMP_BITS'(t);
  endfunction

  function automatic pix_t from_port(port_pix_t p);
    return p[PIXEL_BITS-1:0];
  endfunction

  function automatic port_pix_t to_port(pix_t p);
    port_pix_t r;
    r = '0;
    r[PIXEL_BITS-1:0] = p;
    return r;
  endfunction

endpackage

// ----- hw/rtl/dcr_cfg.sv -----
// ---------------------------------------------------------------------------
// dcr_cfg
// Configuration register file, one write per transfer.
// ---------------------------------------------------------------------------
module dcr_cfg import dcr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  reg_idx_t cfg_index,
  input  thr_t     cfg_data,
  output cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_RESET;
      cfg.luma_spatial    <= LUMA_SPATIAL_RESET;
      cfg.luma_temporal   <= LUMA_TEMPORAL_RESET;
      cfg.chroma_temporal <= CHROMA_TEMPORAL_RESET;
      cfg.chroma_change   <= CHROMA_CHANGE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:            cfg.mode            <= cfg_data[1:0];
        REG_LUMA_SPATIAL:    cfg.luma_spatial    <= cfg_data;
        REG_LUMA_TEMPORAL:   cfg.luma_temporal   <= cfg_data;
        REG_CHROMA_TEMPORAL: cfg.chroma_temporal <= cfg_data;
        REG_CHROMA_CHANGE:   cfg.chroma_change   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dcr_diff.sv -----
// ---------------------------------------------------------------------------
// dcr_diff
// Stage 1: spatial second differences and temporal absolute differences.
// ---------------------------------------------------------------------------
module dcr_diff import dcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output diff_t   out_data
);

  logic   vld;
  diff_t  data;
  diff_t  data_next;
  sdiff_t sum_v, sum_h, twice;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_comb begin
    sum_v = sdiff_t'(in_data.up) + sdiff_t'(in_data.down);
    sum_h = sdiff_t'(in_data.lf) + sdiff_t'(in_data.rt);
    twice = {in_data.cur, 1'b0};
    data_next.cmd    = in_data.cmd;
    data_next.border = in_data.border;
    data_next.cur    = in_data.cur;
    data_next.f1     = in_data.f1;
    data_next.f3     = in_data.f3;
    data_next.sd_v   = (sum_v >= twice) ? sdiff_t'(sum_v - twice) : sdiff_t'(twice - sum_v);
    data_next.sd_h   = (sum_h >= twice) ? sdiff_t'(sum_h - twice) : sdiff_t'(twice - sum_h);
    data_next.d_f0   = abs_diff(in_data.cur, in_data.f0);
    data_next.d_f4   = abs_diff(in_data.cur, in_data.f4);
    data_next.d_13   = abs_diff(in_data.f1, in_data.f3);
    data_next.d_c1   = abs_diff(in_data.cur, in_data.f1);
    data_next.d_c3   = abs_diff(in_data.cur, in_data.f3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ----- hw/rtl/dcr_decide.sv -----
// ---------------------------------------------------------------------------
// dcr_decide
// Stage 2: threshold tests, rule select and choice of the closer frame.
// ---------------------------------------------------------------------------
module dcr_decide import dcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  diff_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pick_t out_data
);

  logic  vld;
  pick_t data;
  pick_t data_next;
  logic  luma_en, chroma_en, flat, luma_tmp, chroma_tmp, chroma_chg;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_comb begin
    luma_en = (in_data.cmd == CMD_LUMA) && cfg.mode[MODE_LUMA_BIT] && !in_data.border;
    chroma_en = (in_data.cmd == CMD_CHROMA) && cfg.mode[MODE_CHROMA_BIT];
    flat = le_thr(CMP_BITS'(in_data.sd_v), cfg.luma_spatial) &&
           le_thr(CMP_BITS'(in_data.sd_h), cfg.luma_spatial);
    luma_tmp = le_thr(CMP_BITS'(in_data.d_f0), cfg.luma_temporal) &&
               le_thr(CMP_BITS'(in_data.d_f4), cfg.luma_temporal) &&
               le_thr(CMP_BITS'(in_data.d_13), cfg.luma_temporal);
    chroma_tmp = le_thr(CMP_BITS'(in_data.d_f0), cfg.chroma_temporal) &&
                 le_thr(CMP_BITS'(in_data.d_f4), cfg.chroma_temporal) &&
                 le_thr(CMP_BITS'(in_data.d_13), cfg.chroma_temporal);
    chroma_chg = !le_thr(CMP_BITS'(in_data.d_c1), cfg.chroma_change) &&
                 !le_thr(CMP_BITS'(in_data.d_c3), cfg.chroma_change);
    data_next.fire  = (luma_en && !flat && luma_tmp) ||
                      (chroma_en && chroma_tmp && chroma_chg);
    data_next.cur   = in_data.cur;
    // tie goes to the later frame
    data_next.other = (in_data.d_c1 < in_data.d_c3) ? in_data.f1 : in_data.f3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ----- hw/rtl/dcr_blend.sv -----
// ---------------------------------------------------------------------------
// dcr_blend
// Stage 3: rounded mean with the chosen frame, and the output register.
// ---------------------------------------------------------------------------
module dcr_blend import dcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pick_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pix_t  out_pix
);

  logic                vld;
  pix_t                pix;
  pix_t                pix_next;
  logic [PIXEL_BITS:0] sum;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_pix   = pix;

  always_comb begin
    sum = (PIXEL_BITS+1)'(in_data.cur) + (PIXEL_BITS+1)'(in_data.other) +
          (PIXEL_BITS+1)'(1);
    pix_next = in_data.fire ? sum[PIXEL_BITS:1] : in_data.cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix <= pix_next;
    end
  end

endmodule

// ----- hw/rtl/dot_crawl_rainbow_pixel_filter_unit.sv -----
// ---------------------------------------------------------------------------
// dot_crawl_rainbow_pixel_filter_unit
// Dot crawl (luma) and rainbow (chroma) removal on a five-frame window,
// one pixel per transfer.
//
//   channel  signals                          direction
//   in       in_valid/in_ready, cmd..two_ahead  into block
//   out      out_valid/out_ready, pixel_out     out of block
//   cfg      cfg_valid/cfg_ready, index, data   into block
//
// Three register stages (differences, threshold tests, blend); one pixel
// can enter per cycle while the output side is ready.
// Each stage has its own valid bit and takes a new pixel when empty or when
// the next stage takes its content, so bubbles close up under a stall.
// Synchronous reset clears the stage valid bits and loads register defaults.
// Config writes take effect on the next cycle and are always accepted.
// ---------------------------------------------------------------------------
module dot_crawl_rainbow_pixel_filter_unit import dcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cmd_t      cmd,
  input  logic      at_border,
  input  port_pix_t center,
  input  port_pix_t above,
  input  port_pix_t below,
  input  port_pix_t left_pixel,
  input  port_pix_t right_pixel,
  input  port_pix_t two_back,
  input  port_pix_t one_back,
  input  port_pix_t one_ahead,
  input  port_pix_t two_ahead,
  output logic      out_valid,
  input  logic      out_ready,
  output port_pix_t pixel_out,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  reg_idx_t  cfg_index,
  input  thr_t      cfg_data
);

  cfg_t    cfg;
  pix_in_t in_data;
  diff_t   s1_data;
  pick_t   s2_data;
  pix_t    s3_pix;
  logic    s1_valid, s1_ready, s2_valid, s2_ready;
  logic [1:0] count;
  logic [1:0] count_next;

  assign in_data.cmd    = cmd;
  assign in_data.border = at_border;
  assign in_data.cur    = from_port(center);
  assign in_data.up     = from_port(above);
  assign in_data.down   = from_port(below);
  assign in_data.lf     = from_port(left_pixel);
  assign in_data.rt     = from_port(right_pixel);
  assign in_data.f0     = from_port(two_back);
  assign in_data.f1     = from_port(one_back);
  assign in_data.f3     = from_port(one_ahead);
  assign in_data.f4     = from_port(two_ahead);

  dcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcr_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  dcr_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  dcr_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (s3_pix)
  );

  assign pixel_out = to_port(s3_pix);

  // pixels in flight, for checking only
  always_comb begin
    count_next = count + 2'((in_valid && in_ready) ? 1 : 0)
                       - 2'((out_valid && out_ready) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != 2'd0))
    else $error("result shown with no pixel in flight");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd3 && !out_ready) |-> !in_ready)
    else $error("pipeline took a pixel while full and stalled");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_MODE) |=> (cfg.mode == $past(cfg_data[1:0])))
    else $error("mode register write lost");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dot_crawl_rainbow_pixel_filter_unit: directed pixels
// at the rule boundaries, register writes over all settings, then random
// pixel windows under random input gaps and output stalls, each result
// compared against a behavioral filter model in order of transfer.
// ----------------------------------------------------------------------------
module tb import dcr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // plane codes with no package constant
  localparam cmd_t CMD_OTHER = 2'd2;
  localparam cmd_t CMD_SPARE = 2'd3;
  // register indexes that decode to nothing
  localparam reg_idx_t REG_SPARE_FIRST = 3'd5;
  localparam reg_idx_t REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    cmd_t      plane;
    logic      border;
    port_pix_t center, above, below, lft, rgt;
    port_pix_t back2, back1, ahead1, ahead2;
  } pix_req_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  pix_req_t  req;
  logic      out_valid;
  logic      out_ready = 1'b0;
  port_pix_t pixel_out;
  logic      cfg_valid;
  logic      cfg_ready;
  reg_idx_t  cfg_index;
  thr_t      cfg_data;

  // filter settings as the block should hold them
  int mode_m, lsp_m, ltp_m, ctp_m, cch_m;

  port_pix_t expected_pix[$];
  int        errors = 0;
  bit        quiet = 1'b0;

  dot_crawl_rainbow_pixel_filter_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (req.plane),
    .at_border  (req.border),
    .center     (req.center),
    .above      (req.above),
    .below      (req.below),
    .left_pixel (req.lft),
    .right_pixel(req.rgt),
    .two_back   (req.back2),
    .one_back   (req.back1),
    .one_ahead  (req.ahead1),
    .two_ahead  (req.ahead2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // rounded mean with the closer neighbor frame, later frame on a tie
  function automatic int blend_closer(int c, int prev, int next);
    int other;
    other = (abs_gap(c, prev) < abs_gap(c, next)) ? prev : next;
    return (c + other + 1) >>> 1;
  endfunction

  function automatic port_pix_t filtered_pixel(pix_req_t p);
    int  msk, c, u, d, l, r, b2, b1, a1, a2, res;
    bit  flat;
    msk = (1 << PIXEL_BITS) - 1;
    c  = p.center & msk;
    u  = p.above & msk;
    d  = p.below & msk;
    l  = p.lft & msk;
    r  = p.rgt & msk;
    b2 = p.back2 & msk;
    b1 = p.back1 & msk;
    a1 = p.ahead1 & msk;
    a2 = p.ahead2 & msk;
    res = c;
    if (p.plane == CMD_LUMA && mode_m[MODE_LUMA_BIT] && !p.border) begin
      flat = abs_gap(u + d, 2 * c) <= lsp_m && abs_gap(l + r, 2 * c) <= lsp_m;
      if (!flat && abs_gap(c, b2) <= ltp_m && abs_gap(c, a2) <= ltp_m &&
          abs_gap(b1, a1) <= ltp_m)
        res = blend_closer(c, b1, a1);
    end else if (p.plane == CMD_CHROMA && mode_m[MODE_CHROMA_BIT]) begin
      if (abs_gap(c, b2) <= ctp_m && abs_gap(c, a2) <= ctp_m && abs_gap(b1, a1) <= ctp_m &&
          abs_gap(c, b1) > cch_m && abs_gap(c, a1) > cch_m)
        res = blend_closer(c, b1, a1);
    end
    return port_pix_t'(res & msk);
  endfunction

  // scoreboard: predicts on each input transfer, checks each output transfer
  always @(posedge clk) begin : check_outputs
    port_pix_t want;
    if (rst) begin
      mode_m = int'(MODE_RESET);
      lsp_m  = int'(LUMA_SPATIAL_RESET);
      ltp_m  = int'(LUMA_TEMPORAL_RESET);
      ctp_m  = int'(CHROMA_TEMPORAL_RESET);
      cch_m  = int'(CHROMA_CHANGE_RESET);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pix.size() == 0) begin
          $error("pixel_out: no pixel outstanding, actual %0d", pixel_out);
          errors++;
        end else begin
          want = expected_pix.pop_front();
          if (pixel_out !== want) begin
            $error("pixel_out: expected %0d, actual %0d", want, pixel_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_pix.push_back(filtered_pixel(req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:            mode_m = int'(cfg_data[1:0]);
          REG_LUMA_SPATIAL:    lsp_m  = int'(cfg_data);
          REG_LUMA_TEMPORAL:   ltp_m  = int'(cfg_data);
          REG_CHROMA_TEMPORAL: ctp_m  = int'(cfg_data);
          REG_CHROMA_CHANGE:   cch_m  = int'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // output backpressure in random bursts
  int  rdy_left = 0;
  bit  rdy_stall = 1'b0;
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      if (rdy_left == 0) begin
        rdy_stall = ($urandom_range(0, 2) == 0);
        rdy_left = rdy_stall ? $urandom_range(1, 16) : $urandom_range(1, 40);
      end
      rdy_left--;
      out_ready <= !rdy_stall;
    end
  end

  function automatic pix_req_t make_pixel(cmd_t plane, logic border, int c, int u, int d,
                                          int l, int r, int b2, int b1, int a1, int a2);
    pix_req_t p;
    p.plane  = plane;
    p.border = border;
    p.center = port_pix_t'(c);
    p.above  = port_pix_t'(u);
    p.below  = port_pix_t'(d);
    p.lft    = port_pix_t'(l);
    p.rgt    = port_pix_t'(r);
    p.back2  = port_pix_t'(b2);
    p.back1  = port_pix_t'(b1);
    p.ahead1 = port_pix_t'(a1);
    p.ahead2 = port_pix_t'(a2);
    return p;
  endfunction

  function automatic int near_value(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // mostly clustered windows so the temporal tests can pass, some pure noise
  function automatic pix_req_t random_pixel();
    pix_req_t p;
    int       k, base, spread;
    k = $urandom_range(0, 9);
    if (k < 4)      p.plane = CMD_LUMA;
    else if (k < 8) p.plane = CMD_CHROMA;
    else if (k == 8) p.plane = CMD_OTHER;
    else            p.plane = CMD_SPARE;
    p.border = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 4) == 0) begin
      p.center = port_pix_t'($urandom_range(0, 65535));
      p.above  = port_pix_t'($urandom_range(0, 65535));
      p.below  = port_pix_t'($urandom_range(0, 65535));
      p.lft    = port_pix_t'($urandom_range(0, 65535));
      p.rgt    = port_pix_t'($urandom_range(0, 65535));
      p.back2  = port_pix_t'($urandom_range(0, 65535));
      p.back1  = port_pix_t'($urandom_range(0, 65535));
      p.ahead1 = port_pix_t'($urandom_range(0, 65535));
      p.ahead2 = port_pix_t'($urandom_range(0, 65535));
    end else begin
      base   = $urandom_range(0, 65535);
      spread = 1 << $urandom_range(6, 14);
      p.center = port_pix_t'(base);
      p.above  = port_pix_t'(near_value(base, spread));
      p.below  = port_pix_t'(near_value(base, spread));
      p.lft    = port_pix_t'(near_value(base, spread));
      p.rgt    = port_pix_t'(near_value(base, spread));
      p.back2  = port_pix_t'(near_value(base, spread));
      p.back1  = port_pix_t'(near_value(base, spread));
      p.ahead1 = port_pix_t'(near_value(base, spread));
      p.ahead2 = port_pix_t'(near_value(base, spread));
    end
    return p;
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 8191);
      4: return $urandom_range(0, 65535);
      default: return $urandom_range(256, 2048);
    endcase
  endfunction

  task automatic send_pixel(pix_req_t p);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // block is idle once every pixel is out and the pipe has had time to empty
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(reg_idx_t idx, int value);
    wait_drained();
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = thr_t'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_defaults();
    program_reg(REG_MODE, int'(MODE_RESET));
    program_reg(REG_LUMA_SPATIAL, int'(LUMA_SPATIAL_RESET));
    program_reg(REG_LUMA_TEMPORAL, int'(LUMA_TEMPORAL_RESET));
    program_reg(REG_CHROMA_TEMPORAL, int'(CHROMA_TEMPORAL_RESET));
    program_reg(REG_CHROMA_CHANGE, int'(CHROMA_CHANGE_RESET));
  endtask

  // pixels that sit right on the decisions at the default settings
  task automatic send_probes();
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 20000, 0, 30000, 0,
                          10000, 10100, 10300, 10000));
    send_pixel(make_pixel(CMD_LUMA, 1'b1, 10000, 20000, 0, 30000, 0,
                          10000, 10100, 10300, 10000));
    send_pixel(make_pixel(CMD_CHROMA, 1'b0, 20000, 0, 0, 0, 0,
                          20000, 22000, 23000, 20000));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 1000, 1000, 1000, 1000, 1000,
                          1000, 1001, 1003, 1000));
    send_pixel(make_pixel(CMD_OTHER, 1'b0, 20000, 0, 0, 0, 0,
                          20000, 22000, 23000, 20000));
  endtask

  task automatic test_defaults();
    send_probes();
    // next frame closer, then a tie
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 20000, 0, 30000, 0,
                          10000, 10300, 10100, 10000));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 20000, 0, 30000, 0,
                          10000, 9900, 10100, 10000));
    // temporal test fails on two frames back
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 20000, 0, 30000, 0,
                          20000, 10100, 10300, 10000));
    // spatial difference exactly at the limit stays flat, one over does not
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 15177, 10000, 10000, 10000,
                          10000, 10100, 10300, 10000));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 10000, 15178, 10000, 10000, 10000,
                          10000, 10100, 10300, 10000));
    // chroma: border has no effect, change just at and just above threshold
    send_pixel(make_pixel(CMD_CHROMA, 1'b1, 20000, 0, 0, 0, 0,
                          20000, 18000, 17000, 20000));
    send_pixel(make_pixel(CMD_CHROMA, 1'b0, 20000, 0, 0, 0, 0,
                          20000, 21245, 22000, 20000));
    send_pixel(make_pixel(CMD_CHROMA, 1'b0, 20000, 0, 0, 0, 0,
                          23801, 21246, 22000, 16199));
    send_pixel(make_pixel(CMD_SPARE, 1'b0, 20000, 0, 0, 0, 0,
                          20000, 22000, 23000, 20000));
    // extremes of the pixel range
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(CMD_CHROMA, 1'b1, 65535, 65535, 65535, 65535, 65535,
                          65535, 65535, 65535, 65535));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 65535, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 0, 65535, 65535, 65535, 65535,
                          65535, 65535, 65535, 65535));
    send_pixel(make_pixel(CMD_LUMA, 1'b0, 65535, 0, 0, 0, 0,
                          65535, 65534, 65533, 65535));
    send_pixel(make_pixel(CMD_CHROMA, 1'b0, 65535, 0, 0, 0, 0,
                          65535, 63000, 62000, 65535));
  endtask

  task automatic test_registers();
    program_reg(REG_MODE, 0);
    send_probes();
    program_reg(REG_MODE, 1);
    send_probes();
    program_reg(REG_MODE, 2);
    send_probes();
    // upper data bits of the mode write are dropped
    program_reg(REG_MODE, 16'hFFFD);
    send_probes();
    program_reg(REG_LUMA_SPATIAL, 0);
    program_reg(REG_LUMA_TEMPORAL, 0);
    program_reg(REG_CHROMA_TEMPORAL, 0);
    program_reg(REG_CHROMA_CHANGE, 0);
    program_reg(REG_MODE, 16'hFFFF);
    send_probes();
    program_reg(REG_LUMA_SPATIAL, 65535);
    program_reg(REG_LUMA_TEMPORAL, 65535);
    program_reg(REG_CHROMA_TEMPORAL, 65535);
    program_reg(REG_CHROMA_CHANGE, 65535);
    send_probes();
    program_reg(REG_LUMA_SPATIAL, 0);
    send_probes();
    load_defaults();
    // writes to undecoded indexes must leave the settings alone
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      program_reg(reg_idx_t'(i), 0);
    send_probes();
  endtask

  task automatic test_random_windows();
    for (int ph = 0; ph < 8; ph++) begin
      program_reg(REG_MODE, ($urandom_range(0, 1) == 0) ? int'(MODE_RESET)
                                                         : $urandom_range(0, 65535));
      program_reg(REG_LUMA_SPATIAL, pick_threshold());
      program_reg(REG_LUMA_TEMPORAL, pick_threshold());
      program_reg(REG_CHROMA_TEMPORAL, pick_threshold());
      program_reg(REG_CHROMA_CHANGE, pick_threshold());
      repeat (110) send_pixel(random_pixel());
    end
    load_defaults();
    // full rate, no gaps and no stalls
    quiet = 1'b1;
    repeat (170) send_pixel(random_pixel());
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_registers();
    test_random_windows();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
